[rtl/core/tss_pkg.sv]
// shared types and constants of the time slot schedule table
// slot entry layout, kind codes, clock limits and the slot test result bundle
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tss_pkg;

  // minutes since midnight, wide enough for hour 31 and minute 63
  localparam int unsigned TIME_W = 11;

  localparam int unsigned MIN_PER_HOUR = 60;
  localparam int unsigned MAX_HOUR     = 23;
  localparam int unsigned MAX_MINUTE   = 59;
  localparam int unsigned SAFE_POWER   = 100;

  // item kinds
  localparam logic [2:0] KIND_LOAD    = 3'd0;
  localparam logic [2:0] KIND_COMMIT  = 3'd1;
  localparam logic [2:0] KIND_CHECK   = 3'd2;
  localparam logic [2:0] KIND_ADVANCE = 3'd3;
  localparam logic [2:0] KIND_LOCATE  = 3'd4;
  localparam logic [2:0] KIND_SET     = 3'd5;

  typedef struct packed {
    logic [7:0] pw;
    logic [5:0] em;
    logic [4:0] eh;
    logic [5:0] sm;
    logic [4:0] sh;
  } tss_entry_t;

  typedef struct packed {
    logic in_slot;
    logic range_ok;
    logic wraps;
  } tss_eval_t;

endpackage

`default_nettype wire

[rtl/core/tss_table.sv]
// slot table memory, one write and one registered read port
// per-entry written bits let an untouched entry read as its reset value
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_table
  import tss_pkg::*;
#(
  parameter int DEPTH = 9
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire tss_entry_t               wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output tss_entry_t                    rd_data,
  output logic                          rd_hit
);

  tss_entry_t             mem [DEPTH];
  logic       [DEPTH-1:0] written_r;
  tss_entry_t             rd_data_r;
  logic                   rd_hit_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      written_r <= '0;
      rd_hit_r  <= 1'b0;
    end else begin
      if (wr_en) begin
        written_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_hit_r <= written_r[rd_addr];
      end
    end
  end

  assign rd_data = rd_data_r;
  assign rd_hit  = rd_hit_r;

endmodule

`default_nettype wire

[rtl/core/tss_eval.sv]
// slot test for one entry: range check, wrap flag and time containment
// depends on tss_pkg
`timescale 1ns / 1ps
`default_nettype none

module tss_eval
  import tss_pkg::*;
(
  input  wire tss_entry_t          entry,
  input  wire logic [TIME_W-1:0]   now,
  output tss_eval_t                result
);

  logic [TIME_W-1:0] start_min;
  logic [TIME_W-1:0] end_min;

  always_comb begin
    start_min = TIME_W'(entry.sh) * TIME_W'(MIN_PER_HOUR) + TIME_W'(entry.sm);
    end_min   = TIME_W'(entry.eh) * TIME_W'(MIN_PER_HOUR) + TIME_W'(entry.em);

    result.wraps    = (start_min >= end_min);
    result.range_ok = (entry.sh <= 5'(MAX_HOUR)) && (entry.eh <= 5'(MAX_HOUR)) &&
                      (entry.sm <= 6'(MAX_MINUTE)) && (entry.em <= 6'(MAX_MINUTE));
    // inclusive bounds, a slot with start after end runs past midnight
    if (start_min <= end_min) begin
      result.in_slot = (now >= start_min) && (now <= end_min);
    end else begin
      result.in_slot = (now >= start_min) || (now <= end_min);
    end
  end

endmodule

`default_nettype wire

[rtl/core/time_slot_schedule_table.sv]
// top level of the daily lamp schedule: sequencer, staging and active tables
// depends on tss_pkg, tss_table and tss_eval
`timescale 1ns / 1ps
`default_nettype none

// Daily lamp-dimming schedule of SLOTS slots, each a start time, an end time
// and a power byte. Each accepted item gives exactly one result. Load writes
// an entry of the staging table; commit checks the staging table (hours up to
// 23, minutes up to 59, at most one slot with start at or after end) and, if
// it passes, copies it into the active table and selects the first slot that
// holds the given time; check tells whether the time lies in the current slot;
// advance, locate and set slot move the current slot. Every result carries
// the current slot index and its power byte. Both tables sit in synchronous
// memories with one write and one read port that are walked one entry per
// cycle. A commit makes a validation pass and then a copy pass over the
// staging table, a locate one pass over the active table; every kind ends
// by reading the power byte of the current slot. The input is ready again
// once the result is registered. One item is in work at a time; a finished
// result waits in the output register while the next item is taken.
// Right after reset the active table holds a safe
// schedule (slot i from i+1:00 to i+2:00, the last slot ending at 01:00,
// power 100) and the staging table holds zeros; no clearing pass is needed.
module time_slot_schedule_table
  import tss_pkg::*;
#(
  parameter int SLOTS = 9
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input item channel
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // tdata from bit 0: slot[3:0], start_hour[8:4], start_minute[14:9],
  // end_hour[19:15], end_minute[25:20], power[33:26], time_hour[38:34],
  // time_minute[44:39], zero fill [47:45]
  input  wire logic [47:0] in_tdata,
  // tuser: kind[2:0]
  input  wire logic [2:0]  in_tuser,
  // result channel
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // tdata from bit 0: accepted[0], in_slot[1], power_level[9:2],
  // current_index[13:10], zero fill [15:14]
  output logic [15:0]      out_tdata
);

  localparam int AW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOAD = 3'd1;
  localparam logic [2:0] S_VAL  = 3'd2;
  localparam logic [2:0] S_COPY = 3'd3;
  localparam logic [2:0] S_LOC  = 3'd4;
  localparam logic [2:0] S_RDPW = 3'd5;
  localparam logic [2:0] S_PW   = 3'd6;

  // safe schedule entry for an active slot never written since reset
  function automatic tss_entry_t safe_entry(input logic [AW-1:0] idx);
    tss_entry_t e;
    e.sh = 5'(idx) + 5'd1;
    e.sm = '0;
    e.eh = (idx == AW'(SLOTS - 1)) ? 5'd1 : 5'(idx) + 5'd2;
    e.em = '0;
    e.pw = 8'(SAFE_POWER);
    return e;
  endfunction

  // control state
  logic [2:0]        state_r, state_nxt;
  logic [AW-1:0]     cur_r, cur_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              pend_r, pend_nxt;
  logic              out_valid_r, out_valid_nxt;

  // item and sweep payload
  logic [2:0]        kind_r, kind_nxt;
  logic [3:0]        slot_r, slot_nxt;
  tss_entry_t        entry_r, entry_nxt;
  logic [TIME_W-1:0] time_r, time_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic              bad_r, bad_nxt;
  logic              wrap_r, wrap_nxt;
  logic              found_r, found_nxt;
  logic              acc_r, acc_nxt;
  logic [15:0]       out_data_r, out_data_nxt;

  // memory ports
  logic              stg_we, stg_re, act_we, act_re;
  logic [AW-1:0]     stg_waddr, stg_raddr, act_waddr, act_raddr;
  tss_entry_t        stg_wdata, act_wdata;
  tss_entry_t        stg_rdata, act_rdata;
  logic              stg_hit, act_hit;

  tss_entry_t        stg_entry, act_entry, ev_entry;
  tss_eval_t         ev;

  logic              accept;
  logic              issue;
  logic [AW-1:0]     issue_idx;

  tss_table #(.DEPTH(SLOTS)) u_staged (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (stg_we),
    .wr_addr (stg_waddr),
    .wr_data (stg_wdata),
    .rd_en   (stg_re),
    .rd_addr (stg_raddr),
    .rd_data (stg_rdata),
    .rd_hit  (stg_hit)
  );

  tss_table #(.DEPTH(SLOTS)) u_active (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (act_we),
    .wr_addr (act_waddr),
    .wr_data (act_wdata),
    .rd_en   (act_re),
    .rd_addr (act_raddr),
    .rd_data (act_rdata),
    .rd_hit  (act_hit)
  );

  // untouched entries read as their reset contents
  assign stg_entry = stg_hit ? stg_rdata : '0;
  assign act_entry = act_hit ? act_rdata : safe_entry(pidx_r);
  // the sweeps over the staging table test staged data, all else the active table
  assign ev_entry  = (state_r == S_VAL || state_r == S_COPY) ? stg_entry : act_entry;

  tss_eval u_eval (
    .entry  (ev_entry),
    .now    (time_r),
    .result (ev)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  assign issue      = (cnt_r < CW'(SLOTS));
  assign issue_idx  = cnt_r[AW-1:0];
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    cnt_nxt       = cnt_r;
    pend_nxt      = pend_r;
    out_valid_nxt = out_valid_r;
    kind_nxt      = kind_r;
    slot_nxt      = slot_r;
    entry_nxt     = entry_r;
    time_nxt      = time_r;
    pidx_nxt      = pidx_r;
    bad_nxt       = bad_r;
    wrap_nxt      = wrap_r;
    found_nxt     = found_r;
    acc_nxt       = acc_r;
    out_data_nxt  = out_data_r;

    stg_we    = 1'b0;
    stg_waddr = slot_r[AW-1:0];
    stg_wdata = entry_r;
    stg_re    = 1'b0;
    stg_raddr = issue_idx;
    act_we    = 1'b0;
    act_waddr = pidx_r;
    act_wdata = stg_entry;
    act_re    = 1'b0;
    act_raddr = issue_idx;

    // result taken by the consumer
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          kind_nxt     = in_tuser;
          slot_nxt     = in_tdata[3:0];
          entry_nxt.sh = in_tdata[8:4];
          entry_nxt.sm = in_tdata[14:9];
          entry_nxt.eh = in_tdata[19:15];
          entry_nxt.em = in_tdata[25:20];
          entry_nxt.pw = in_tdata[33:26];
          time_nxt     = TIME_W'(in_tdata[38:34]) * TIME_W'(MIN_PER_HOUR) +
                         TIME_W'(in_tdata[44:39]);
          acc_nxt      = 1'b1;
          cnt_nxt      = '0;
          pend_nxt     = 1'b0;
          bad_nxt      = 1'b0;
          wrap_nxt     = 1'b0;
          found_nxt    = 1'b0;
          case (in_tuser)
            KIND_LOAD:   state_nxt = S_LOAD;
            KIND_COMMIT: state_nxt = S_VAL;
            KIND_LOCATE: state_nxt = S_LOC;
            KIND_ADVANCE: begin
              cur_nxt   = (cur_r == AW'(SLOTS - 1)) ? '0 : cur_r + AW'(1);
              state_nxt = S_RDPW;
            end
            KIND_SET: begin
              if ({1'b0, in_tdata[3:0]} < 5'(SLOTS)) begin
                cur_nxt = in_tdata[AW-1:0];
              end
              state_nxt = S_RDPW;
            end
            default: state_nxt = S_RDPW;
          endcase
        end
      end

      S_LOAD: begin
        // slot indexes past the table are dropped
        stg_we    = ({1'b0, slot_r} < 5'(SLOTS));
        state_nxt = S_RDPW;
      end

      S_VAL, S_COPY, S_LOC: begin
        // issue one read per cycle, evaluate each read in the cycle after its issue
        if (issue) begin
          stg_re   = (state_r != S_LOC);
          act_re   = (state_r == S_LOC);
          cnt_nxt  = cnt_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = issue_idx;
        end else begin
          pend_nxt = 1'b0;
        end

        if (pend_r) begin
          case (state_r)
            S_VAL: begin
              if (!ev.range_ok) begin
                bad_nxt = 1'b1;
              end
              if (ev.wraps) begin
                if (wrap_r) begin
                  bad_nxt = 1'b1;
                end
                wrap_nxt = 1'b1;
              end
            end
            S_COPY: begin
              act_we = 1'b1;
              // first slot holding the time wins
              if (ev.in_slot && !found_r) begin
                found_nxt = 1'b1;
                cur_nxt   = pidx_r;
              end
            end
            default: begin
              // locate: last slot holding the time wins
              if (ev.in_slot) begin
                cur_nxt = pidx_r;
              end
            end
          endcase
        end

        if (!issue && !pend_r) begin
          if (state_r == S_VAL && !bad_r) begin
            cnt_nxt   = '0;
            found_nxt = 1'b0;
            state_nxt = S_COPY;
          end else begin
            if (state_r == S_VAL) begin
              acc_nxt = 1'b0;
            end
            state_nxt = S_RDPW;
          end
        end
      end

      S_RDPW: begin
        act_re    = 1'b1;
        act_raddr = cur_r;
        pidx_nxt  = cur_r;
        state_nxt = S_PW;
      end

      S_PW: begin
        // read data holds while the output register is still full
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {2'b00, 4'(cur_r), act_entry.pw,
                           (kind_r == KIND_CHECK) && ev.in_slot, acc_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cur_r       <= '0;
      cnt_r       <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cur_r       <= cur_nxt;
      cnt_r       <= cnt_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    slot_r     <= slot_nxt;
    entry_r    <= entry_nxt;
    time_r     <= time_nxt;
    pidx_r     <= pidx_nxt;
    bad_r      <= bad_nxt;
    wrap_r     <= wrap_nxt;
    found_r    <= found_nxt;
    acc_r      <= acc_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

`default_nettype wire

[tb/sv/time_slot_schedule_table_test.sv]
// self-checking bench for the daily lamp schedule table: directed and random item streams,
// a predictor of every result and a field-by-field compare on the result channel
// depends on tss_pkg and time_slot_schedule_table
`timescale 1ns / 1ps

module time_slot_schedule_table_test;
  import tss_pkg::*;

  localparam int SLOTS = 9;
  // kinds the block leaves unused, they only echo the current slot
  localparam logic [2:0] KIND_SPARE6 = 3'd6;
  localparam logic [2:0] KIND_SPARE7 = 3'd7;
  localparam int unsigned DAY_MINUTES = 24 * MIN_PER_HOUR;

  localparam int RANDOM_ITEMS = 1300;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int IDLE_PCT     = 19;
  // transfers in this window see no idling on either side
  localparam int CALM_FIRST   = 400;
  localparam int CALM_LAST    = 700;
  // the receiver holds off once this many results have arrived
  localparam int HOLD_AT      = 1000;
  localparam int HOLD_CYCLES  = 300;
  // long enough for a commit, the longest item, so this covers anything still in work
  localparam int DRAIN_CYCLES = 4 * SLOTS + 12;

  typedef struct packed {
    logic [2:0] kind;
    logic [3:0] slot;
    tss_entry_t entry;
    logic [4:0] th;
    logic [5:0] tm;
  } sched_item_t;

  typedef struct packed {
    logic       accepted;
    logic       in_slot;
    logic [7:0] power;
    logic [3:0] index;
  } lamp_result_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [47:0] in_tdata   = '0;
  logic [2:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;

  // predictor state: staging table, active table, current slot
  tss_entry_t staged_sched [SLOTS];
  tss_entry_t active_sched [SLOTS];
  logic [3:0] cur_slot;

  sched_item_t  pending_items [$];
  lamp_result_t expected_results [$];

  int mismatches      = 0;
  int items_queued    = 0;
  int items_sent      = 0;
  int results_seen    = 0;
  int commits_taken   = 0;
  int commits_refused = 0;
  int slot_hits       = 0;
  int cycle_count     = 0;
  int hold_left       = 0;
  bit hold_done       = 1'b0;

  time_slot_schedule_table #(
    .SLOTS(SLOTS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  // inclusive bounds; start past end means the slot runs over midnight
  function automatic bit covers_time(tss_entry_t e, int unsigned t);
    int unsigned s, f;
    s = e.sh * MIN_PER_HOUR + e.sm;
    f = e.eh * MIN_PER_HOUR + e.em;
    if (s <= f) return t >= s && t <= f;
    return t >= s || t <= f;
  endfunction

  // clock fields in range and at most one slot over midnight (start >= end)
  function automatic bit staging_ok();
    int wraps;
    wraps = 0;
    for (int i = 0; i < SLOTS; i++) begin
      if (staged_sched[i].sh > MAX_HOUR || staged_sched[i].eh > MAX_HOUR) return 1'b0;
      if (staged_sched[i].sm > MAX_MINUTE || staged_sched[i].em > MAX_MINUTE) return 1'b0;
      if (staged_sched[i].sh * MIN_PER_HOUR + staged_sched[i].sm >=
          staged_sched[i].eh * MIN_PER_HOUR + staged_sched[i].em) wraps++;
    end
    return wraps <= 1;
  endfunction

  function automatic lamp_result_t schedule_step(sched_item_t it);
    lamp_result_t r;
    int unsigned  t;
    bit           found;
    t = it.th * MIN_PER_HOUR + it.tm;
    r.accepted = 1'b1;
    r.in_slot  = 1'b0;
    found      = 1'b0;
    case (it.kind)
      KIND_LOAD: begin
        if (it.slot < SLOTS) staged_sched[it.slot] = it.entry;
      end
      KIND_COMMIT: begin
        if (staging_ok()) begin
          active_sched = staged_sched;
          commits_taken++;
          // first slot holding the time wins, none leaves the slot alone
          for (int i = 0; i < SLOTS; i++) begin
            if (!found && covers_time(active_sched[i], t)) begin
              cur_slot = 4'(i);
              found    = 1'b1;
            end
          end
        end else begin
          r.accepted = 1'b0;
          commits_refused++;
        end
      end
      KIND_CHECK: begin
        r.in_slot = covers_time(active_sched[cur_slot], t);
        if (r.in_slot) slot_hits++;
      end
      KIND_ADVANCE: begin
        cur_slot = (cur_slot + 1 >= SLOTS) ? 4'd0 : cur_slot + 4'd1;
      end
      KIND_LOCATE: begin
        // last slot holding the time wins
        for (int i = 0; i < SLOTS; i++) begin
          if (covers_time(active_sched[i], t)) cur_slot = 4'(i);
        end
      end
      KIND_SET: begin
        if (it.slot < SLOTS) cur_slot = it.slot;
      end
      default: begin
      end
    endcase
    r.power = active_sched[cur_slot].pw;
    r.index = cur_slot;
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  function automatic sched_item_t op_item(logic [2:0] k, logic [3:0] slot_no,
                                          logic [4:0] h, logic [5:0] m);
    sched_item_t it;
    it      = '0;
    it.kind = k;
    it.slot = slot_no;
    it.th   = h;
    it.tm   = m;
    return it;
  endfunction

  // entry from start and end given in minutes since midnight
  function automatic sched_item_t load_item(logic [3:0] slot_no, int unsigned s,
                                            int unsigned f, logic [7:0] pw);
    sched_item_t it;
    it          = op_item(KIND_LOAD, slot_no, 5'd0, 6'd0);
    it.entry.sh = 5'(s / MIN_PER_HOUR);
    it.entry.sm = 6'(s % MIN_PER_HOUR);
    it.entry.eh = 5'(f / MIN_PER_HOUR);
    it.entry.em = 6'(f % MIN_PER_HOUR);
    it.entry.pw = pw;
    return it;
  endfunction

  // loads and set slot past the table and the spare kinds change nothing
  function automatic void queue_item(sched_item_t it);
    pending_items.push_back(it);
    if (!(((it.kind == KIND_LOAD) || (it.kind == KIND_SET)) && it.slot >= SLOTS) &&
        it.kind != KIND_SPARE6 && it.kind != KIND_SPARE7) items_queued++;
  endfunction

  // mostly a valid clock time, now and then anything the fields hold
  function automatic sched_item_t timed_item(logic [2:0] k, logic [3:0] slot_no);
    if ($urandom_range(99) < 10) begin
      return op_item(k, slot_no, 5'($urandom_range(31)), 6'($urandom_range(63)));
    end
    return op_item(k, slot_no, 5'($urandom_range(MAX_HOUR)), 6'($urandom_range(MAX_MINUTE)));
  endfunction

  function automatic sched_item_t random_op();
    int pick;
    pick = $urandom_range(99);
    if (pick < 40) return timed_item(KIND_CHECK, 4'($urandom_range(15)));
    if (pick < 60) return timed_item(KIND_ADVANCE, 4'($urandom_range(15)));
    if (pick < 80) return timed_item(KIND_LOCATE, 4'($urandom_range(15)));
    if (pick < 92) return timed_item(KIND_SET, 4'($urandom_range(SLOTS - 1)));
    return timed_item(KIND_SET, 4'($urandom_range(15)));
  endfunction

  // a full table that passes the commit, with at most one slot over midnight
  function automatic void queue_schedule();
    int wrap_at;
    int unsigned s, f;
    wrap_at = $urandom_range(SLOTS + 2);
    for (int i = 0; i < SLOTS; i++) begin
      if (i == wrap_at) begin
        s = $urandom_range(DAY_MINUTES - 1);
        f = $urandom_range(s);
      end else begin
        s = $urandom_range(DAY_MINUTES - 2);
        f = $urandom_range(DAY_MINUTES - 1, s + 1);
      end
      queue_item(load_item(4'(i), s, f, 8'($urandom_range(255))));
    end
  endfunction

  // single entry edit, often over midnight or with a clock field out of range
  function automatic sched_item_t rough_load();
    sched_item_t it;
    it = load_item(4'($urandom_range(SLOTS - 1)), $urandom_range(DAY_MINUTES - 1),
                   $urandom_range(DAY_MINUTES - 1), 8'($urandom_range(255)));
    case ($urandom_range(9))
      0: it.entry.sh = 5'($urandom_range(31, MAX_HOUR + 1));
      1: it.entry.eh = 5'($urandom_range(31, MAX_HOUR + 1));
      2: it.entry.sm = 6'($urandom_range(63, MAX_MINUTE + 1));
      3: it.entry.em = 6'($urandom_range(63, MAX_MINUTE + 1));
      default: begin
      end
    endcase
    return it;
  endfunction

  function automatic sched_item_t noise_item();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[47:0];
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // input side: offer the head of the pending queue, hold it until taken
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : feed
    logic        offer;
    sched_item_t head;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else begin
      if (in_tvalid && in_tready) begin
        // prediction runs at the transfer, in order of acceptance
        expected_results.push_back(schedule_step(pending_items.pop_front()));
        items_sent++;
      end
      offer = in_tvalid && !in_tready;
      if (!offer && pending_items.size() != 0) begin
        offer = (items_sent >= CALM_FIRST && items_sent < CALM_LAST) ||
                $urandom_range(99) >= IDLE_PCT;
      end
      in_tvalid <= offer;
      if (offer) begin
        head = pending_items[0];
        in_tdata <= {3'b000, head.tm, head.th, head.entry.pw, head.entry.em, head.entry.eh,
                     head.entry.sm, head.entry.sh, head.slot};
        in_tuser <= head.kind;
      end
    end
  end

  // one long hold-off of the receiver so the block backs up into its input
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end else if (!hold_done && results_seen >= HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result side: compare each transfer with the oldest expectation
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : watch
    lamp_result_t want;
    logic         ready;
    if (rst_n && out_tvalid && out_tready) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        $display("%0t ns: result expected none, got %h", $time, out_tdata);
        mismatches++;
      end else begin
        want = expected_results.pop_front();
        check_field("accepted", 32'(want.accepted), 32'(out_tdata[0]));
        check_field("in_slot", 32'(want.in_slot), 32'(out_tdata[1]));
        check_field("power_level", 32'(want.power), 32'(out_tdata[9:2]));
        check_field("current_index", 32'(want.index), 32'(out_tdata[13:10]));
      end
    end
    if (!rst_n || hold_left != 0) begin
      ready = 1'b0;
    end else if (results_seen >= CALM_FIRST && results_seen < CALM_LAST) begin
      ready = 1'b1;
    end else begin
      ready = $urandom_range(99) >= IDLE_PCT;
    end
    out_tready <= ready;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still owed", cycle_count,
               expected_results.size() + pending_items.size());
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    sched_item_t it;
    int          random_goal;
    int          pick;

    // state right after reset: zeros staged, safe hourly schedule active
    for (int i = 0; i < SLOTS; i++) begin
      staged_sched[i] = '0;
      active_sched[i] = '{pw: 8'(SAFE_POWER), em: 6'd0, eh: 5'(i + 2), sm: 6'd0,
                          sh: 5'(i + 1)};
    end
    active_sched[SLOTS - 1].eh = 5'd1;
    cur_slot = 4'd0;

    // directed: the safe schedule, wrap of advance, ignored indexes and kinds
    queue_item(op_item(KIND_CHECK, 4'd0, 5'd1, 6'd30));
    queue_item(op_item(KIND_CHECK, 4'd0, 5'd0, 6'd0));
    queue_item(op_item(KIND_LOCATE, 4'd0, 5'd0, 6'd30));
    queue_item(op_item(KIND_ADVANCE, 4'd0, 5'd0, 6'd0));
    queue_item(op_item(KIND_SET, 4'd15, 5'd0, 6'd0));
    queue_item(op_item(KIND_SET, 4'(SLOTS - 1), 5'd0, 6'd0));
    queue_item(op_item(KIND_ADVANCE, 4'd0, 5'd0, 6'd0));
    queue_item(op_item(KIND_SPARE6, 4'd15, 5'd31, 6'd63));
    queue_item(op_item(KIND_SPARE7, 4'd0, 5'd0, 6'd0));
    // all-zero staging: every slot counts as over midnight, so refused
    queue_item(op_item(KIND_COMMIT, 4'd0, 5'd12, 6'd0));
    it       = op_item(KIND_LOAD, 4'd15, 5'd31, 6'd63);
    it.entry = '1;
    queue_item(it);
    // three-hour slots up to 23:59, last slot 23:59 over midnight to 00:00
    for (int i = 0; i < SLOTS - 1; i++) begin
      queue_item(load_item(4'(i), i * 180, i * 180 + 179, 8'(i * 36)));
    end
    queue_item(load_item(4'(SLOTS - 1), DAY_MINUTES - 1, 0, 8'hff));
    queue_item(op_item(KIND_COMMIT, 4'd0, 5'(MAX_HOUR), 6'(MAX_MINUTE)));
    queue_item(op_item(KIND_LOCATE, 4'd0, 5'(MAX_HOUR), 6'(MAX_MINUTE)));
    queue_item(op_item(KIND_CHECK, 4'd0, 5'd0, 6'd0));
    queue_item(op_item(KIND_LOCATE, 4'd0, 5'd31, 6'd63));
    // minute 60 in one entry makes the table invalid
    it          = load_item(4'd3, 540, 600, 8'd77);
    it.entry.sm = 6'd60;
    queue_item(it);
    queue_item(op_item(KIND_COMMIT, 4'd0, 5'd9, 6'd30));

    // random: mostly whole valid tables then queries, some edits, some noise
    random_goal = items_queued + RANDOM_ITEMS;
    while (items_queued < random_goal) begin
      pick = $urandom_range(99);
      if (pick < 55) begin
        queue_schedule();
        queue_item(timed_item(KIND_COMMIT, 4'($urandom_range(15))));
        repeat ($urandom_range(10, 3)) queue_item(random_op());
      end else if (pick < 80) begin
        repeat ($urandom_range(3, 1)) queue_item(rough_load());
        queue_item(timed_item(KIND_COMMIT, 4'($urandom_range(15))));
        repeat ($urandom_range(4, 1)) queue_item(random_op());
      end else begin
        repeat ($urandom_range(6, 1)) queue_item(noise_item());
      end
    end

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_items.size() != 0 || in_tvalid || expected_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("%0d transfers checked: %0d commits taken, %0d refused, %0d checks in slot",
             results_seen, commits_taken, commits_refused, slot_hits);
    $display("receiver held off %0d cycles once, idling %0d%% on both sides otherwise",
             HOLD_CYCLES, IDLE_PCT);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tss_pkg.sv
rtl/core/tss_table.sv
rtl/core/tss_eval.sv
rtl/core/time_slot_schedule_table.sv
tb/sv/time_slot_schedule_table_test.sv
